/* design/mrfc_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// frame checker. No dependencies; every other file imports this package.
package mrfc_pkg;

  localparam int PAYLOAD_MAX = 256;          // payload beats forwarded per frame
  localparam int PAY_LIMIT   = PAYLOAD_MAX + 4;
  localparam int FIFO_DEPTH  = 4;

  localparam logic [10:0] COUNT_SAT = 11'h7FF;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  localparam logic [31:0] MASK_RESET     = 32'd29460990;
  localparam logic [7:0]  MAX_ADDR_RESET = 8'd247;
  localparam logic [10:0] MAX_LEN_RESET  = 11'd256;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_MASK     = 2'd0;
  localparam logic [1:0] CFG_IDX_MAX_ADDR = 2'd1;
  localparam logic [1:0] CFG_IDX_MAX_LEN  = 2'd2;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [31:0] function_mask;
    logic [7:0]  max_address;
    logic [10:0] max_length;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       detected;
    logic       crc_ok;
    logic       length_ok;
    logic [7:0] dst_address;
    logic [7:0] function_code;
    logic [8:0] payload_length;
    logic       last_of_run;
  } result_t;

  // reflected CRC-16, one byte, LSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/modbus_rtu_frame_checker_top.sv */
// Top level of the Modbus RTU frame checker: input register, configuration
// registers, core and result queue. Depends on mrfc_pkg, mrfc_core, mrfc_fifo.
//
// Usage:
//   s_* : one frame byte per beat in s_tdata[7:0], s_tlast on the final byte.
//   m_* : one result per beat. m_tuser is the kind (0 payload, 1 summary),
//         m_tlast marks the final result caused by one input byte.
//   cfg_*: register writes (0 function mask, 1 max address, 2 max frame
//         length); always ready, other indexes are ignored. Write only idle.
// Each byte past the first four yields a payload beat carrying the byte two
// places back (up to 256 per frame); the last byte adds a summary beat.
// Path from an input beat to its first result beat: input register, result
// queue, output register.
// Throughput: one byte per cycle while the queue has room; the byte-wide CRC
// step and the one-beat output port set this, so a frame end that causes two
// results takes an extra output beat, absorbed by the four-entry queue.
// Reset clears frame state, restores register defaults and empties the queue.
// When m_tready is low, results collect in the queue; once fewer than two
// slots are free, s_tready drops and the held input byte waits.
module modbus_rtu_frame_checker_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_frame
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // payload_byte, detected, crc_ok, length_ok,
                                 // dst_address, function_code, payload_length, zero fill
  output logic        m_tuser,   // kind
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mrfc_pkg::*;

  cfg_t       cfg;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eof;
  logic       room2, advance;
  logic [1:0] push_n;
  result_t    res0, res1, out_res;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && room2;
  assign s_tready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_mask <= MASK_RESET;
      cfg.max_address   <= MAX_ADDR_RESET;
      cfg.max_length    <= MAX_LEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_IDX_MASK) begin
        cfg.function_mask <= cfg_data;
      end else if (cfg_index == CFG_IDX_MAX_ADDR) begin
        cfg.max_address <= cfg_data[7:0];
      end else if (cfg_index == CFG_IDX_MAX_LEN) begin
        cfg.max_length <= cfg_data[10:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_eof  <= s_tlast;
    end
  end

  mrfc_core u_core (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .data_byte    (in_byte),
    .end_of_frame (in_eof),
    .cfg          (cfg),
    .push_n       (push_n),
    .res0         (res0),
    .res1         (res1)
  );

  mrfc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_n    (push_n),
    .wr0       (res0),
    .wr1       (res1),
    .room2     (room2),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tuser = out_res.kind;
  assign m_tlast = out_res.last_of_run;
  assign m_tdata = {4'd0, out_res.payload_length, out_res.function_code,
                    out_res.dst_address, out_res.length_ok, out_res.crc_ok,
                    out_res.detected, out_res.payload_byte};

endmodule

/* design/mrfc_core.sv */
// Per-frame state of the checker: byte count, delay line, CRC, address and
// function code. Forms up to two results per byte. Uses mrfc_pkg.
module mrfc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic [7:0]       data_byte,
  input  logic             end_of_frame,
  input  mrfc_pkg::cfg_t   cfg,
  output logic [1:0]       push_n,
  output mrfc_pkg::result_t res0,
  output mrfc_pkg::result_t res1
);
  import mrfc_pkg::*;

  logic [10:0] byte_count, count_next;
  logic [15:0] crc_acc, crc_next;
  logic [7:0]  delay0, delay1;
  logic [7:0]  held_address, address_next;
  logic [7:0]  held_function, function_next;

  logic        pay_hit;
  logic        len_ok, addr_ok, func_ok, crc_ok;
  logic [10:0] plen;
  result_t     pay_res, sum_res;

  always_comb begin
    address_next  = held_address;
    function_next = held_function;
    if (byte_count == 11'd0) begin
      address_next = data_byte;
    end else if (byte_count == 11'd1) begin
      function_next = data_byte;
    end

    crc_next = (byte_count >= 11'd2) ? crc_byte(crc_acc, delay1) : crc_acc;
    pay_hit  = (byte_count >= 11'd4) && ({1'b0, byte_count} < 12'(PAY_LIMIT));
    count_next = (byte_count != COUNT_SAT) ? byte_count + 11'd1 : byte_count;

    // after the shift, the received CRC is old delay0 (low) and this byte (high)
    len_ok  = (count_next >= 11'd4) && (count_next != COUNT_SAT) &&
              (count_next <= cfg.max_length);
    crc_ok  = (count_next >= 11'd4) && ({data_byte, delay0} == crc_next);
    addr_ok = address_next <= cfg.max_address;
    func_ok = (function_next[7:5] == 3'd0) && cfg.function_mask[function_next[4:0]];
    if (count_next < 11'd4) begin
      plen = 11'd0;
    end else if (count_next - 11'd4 > 11'(PAYLOAD_MAX)) begin
      plen = 11'(PAYLOAD_MAX);
    end else begin
      plen = count_next - 11'd4;
    end

    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = delay1;
    pay_res.last_of_run  = !end_of_frame;

    sum_res                = '0;
    sum_res.kind           = KIND_SUMMARY;
    sum_res.detected       = len_ok && addr_ok && func_ok && crc_ok;
    sum_res.crc_ok         = crc_ok;
    sum_res.length_ok      = len_ok;
    sum_res.dst_address    = address_next;
    sum_res.function_code  = function_next;
    sum_res.payload_length = plen[8:0];
    sum_res.last_of_run    = 1'b1;

    res0   = pay_hit ? pay_res : sum_res;
    res1   = sum_res;
    push_n = 2'(pay_hit) + 2'(end_of_frame);
    if (!advance) begin
      push_n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && end_of_frame)) begin
      byte_count    <= '0;
      crc_acc       <= CRC_INIT;
      delay0        <= '0;
      delay1        <= '0;
      held_address  <= '0;
      held_function <= '0;
    end else if (advance) begin
      byte_count    <= count_next;
      crc_acc       <= crc_next;
      delay0        <= data_byte;
      delay1        <= delay0;
      held_address  <= address_next;
      held_function <= function_next;
    end
  end

  a_count_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && end_of_frame) |=> (byte_count == 11'd0))
    else $error("byte count not cleared after end of frame");
  a_two_means_payload_first: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> (res0.kind == KIND_PAYLOAD && res1.kind == KIND_SUMMARY))
    else $error("result order wrong on double push");
  a_detected_needs_crc: assert property (@(posedge clk) disable iff (rst)
    sum_res.detected |-> (sum_res.crc_ok && sum_res.length_ok))
    else $error("detected without crc and length ok");

endmodule

/* design/mrfc_fifo.sv */
// Result queue: takes up to two results per cycle, hands one per cycle, when
// the output is not stalled, to a registered output beat. Uses mrfc_pkg.
module mrfc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  mrfc_pkg::result_t wr0,
  input  mrfc_pkg::result_t wr1,
  output logic              room2,
  output logic              out_valid,
  input  logic              out_ready,
  output mrfc_pkg::result_t out_res
);
  import mrfc_pkg::*;

  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  result_t        entries [FIFO_DEPTH];
  logic [PW-1:0]  wptr, rptr;
  logic [CW-1:0]  count, count_next;
  logic           pop;

  assign room2      = count <= CW'(FIFO_DEPTH - 2);
  assign pop        = (count != '0) && (!out_valid || out_ready);
  assign count_next = count + CW'(push_n) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wptr] <= wr0;
    end
    if (push_n == 2'd2) begin
      entries[wptr + PW'(1)] <= wr1;
    end
    if (pop) begin
      out_res <= entries[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      rptr      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      wptr  <= wptr + PW'(push_n);
      rptr  <= rptr + PW'(pop);
      count <= count_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push_n == 2'd2) |-> room2)
    else $error("double push without room");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) + CW'($past(push_n)) - CW'($past(pop))))
    else $error("queue count out of step");

endmodule
